// File: rtl/ptms_pkg.sv
// Package for the priority tone and melody sequencer.
// Holds payload structs, command and mode codes, and the pitch table.
// No dependencies.
package ptms_pkg;

  localparam int MELODY_DEPTH = 16;
  localparam int STEP_IDX_W   = (MELODY_DEPTH > 1) ? $clog2(MELODY_DEPTH) : 1;
  localparam int STEP_CNT_W   = $clog2(MELODY_DEPTH + 1);

  localparam int          NOTE_COUNT       = 13;
  localparam logic [15:0] NOTE_LENGTH_INIT = 16'd80;
  localparam logic [15:0] REST_CODE_INIT   = 16'd0;

  // Configuration register indexes (byte address 4*i)
  localparam logic REG_REST_CODE   = 1'b0;
  localparam logic REG_NOTE_LENGTH = 1'b1;

  typedef enum logic [2:0] {
    CMD_TICK   = 3'd0,
    CMD_TONE   = 3'd1,
    CMD_MELODY = 3'd2,
    CMD_NOTE   = 3'd3,
    CMD_STOP   = 3'd4
  } cmd_t;

  typedef enum logic [3:0] {
    MODE_IDLE    = 4'b0001,
    MODE_TONE    = 4'b0010,
    MODE_MELODY  = 4'b0100,
    MODE_LOADING = 4'b1000
  } mode_t;

  typedef struct packed {
    logic [2:0]  command;
    logic [15:0] frequency;
    logic [15:0] duration;
    logic [1:0]  priority_req;
    logic [3:0]  note_index;
    logic        last_step;
  } in_t;

  typedef struct packed {
    logic [15:0] tone_freq;
    logic        playing;
    logic        accepted;
  } out_t;

  typedef struct packed {
    logic [15:0] duration;
    logic [15:0] frequency;
  } step_t;

  // Equal-tempered pitches C5 up to A6
  function automatic logic [15:0] pitch_of(input logic [3:0] idx);
    logic [15:0] p;
    case (idx)
      4'd0:    p = 16'd523;
      4'd1:    p = 16'd587;
      4'd2:    p = 16'd659;
      4'd3:    p = 16'd698;
      4'd4:    p = 16'd784;
      4'd5:    p = 16'd880;
      4'd6:    p = 16'd988;
      4'd7:    p = 16'd1047;
      4'd8:    p = 16'd1175;
      4'd9:    p = 16'd1319;
      4'd10:   p = 16'd1397;
      4'd11:   p = 16'd1568;
      4'd12:   p = 16'd1760;
      default: p = 16'd0;
    endcase
    return p;
  endfunction

endpackage

// File: rtl/priority_tone_melody_sequencer.sv
// Priority tone and melody sequencer, top level.
// Depends on ptms_pkg for payload structs, codes and the pitch table.
//
// Usage:
//   in channel  : one command per transfer (tick, tone, melody step, table
//                 note, stop), packed as ptms_pkg::in_t on in_data.
//   out channel : one ptms_pkg::out_t result per command: frequency now driven
//                 (0 is silent), playing flag, and priority-check outcome.
//   cfg port    : APB-style, rest_code at byte 0, note_length_ms at byte 4,
//                 16-bit values in a 32-bit data word; pready is always high.
// Timing:
//   All state updates at the input transfer edge; the result is loaded into the output
//   register at that same edge. One command per cycle is sustained while the receiver does not stall.
// Stall:
//   While the output register holds a result that the receiver stalls,
//   in_stall is raised and no command is taken; full rate resumes once it drains.
// Reset:
//   rst_n low clears mode, priority and counters and loads rest_code 0 and
//   note_length_ms 80. The step store is not cleared; only entries written by
//   the current load are ever read.
module priority_tone_melody_sequencer
  import ptms_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  output logic        in_stall,
  input  in_t         in_data,

  output logic        out_valid,
  input  logic        out_stall,
  output out_t        out_data,

  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [15:0] rest_code_r;
  logic [15:0] note_len_r;
  logic        cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rest_code_r <= REST_CODE_INIT;
      note_len_r  <= NOTE_LENGTH_INIT;
    end else if (cfg_wr) begin
      if (cfg_paddr[2] == REG_REST_CODE) begin
        rest_code_r <= cfg_pwdata[15:0];
      end else begin
        note_len_r <= cfg_pwdata[15:0];
      end
    end
  end

  always_comb begin
    if (cfg_paddr[2] == REG_NOTE_LENGTH) begin
      cfg_prdata = {16'd0, note_len_r};
    end else begin
      cfg_prdata = {16'd0, rest_code_r};
    end
  end

  // ---------------------------------------------------------------------
  // Handshake: one output register, input stalls only while it is blocked
  // ---------------------------------------------------------------------
  logic out_valid_r;
  out_t out_data_r;
  logic in_fire;

  assign in_stall  = out_valid_r && out_stall;
  assign in_fire   = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ---------------------------------------------------------------------
  // Sequencer state
  // ---------------------------------------------------------------------
  mode_t                 mode_r,    mode_nxt;
  logic [1:0]            prio_r,    prio_nxt;
  logic [15:0]           len_r,     len_nxt;     // tone length or current step length
  logic [15:0]           elapsed_r, elapsed_nxt;
  logic [STEP_CNT_W-1:0] total_r,   total_nxt;
  logic [STEP_CNT_W-1:0] pos_r,     pos_nxt;
  logic                  load_acc_r, load_acc_nxt;
  logic                  load_open_r, load_open_nxt;
  logic [15:0]           freq_r,    freq_nxt;

  step_t                 store_r [MELODY_DEPTH];
  logic                  st_wr_en;
  logic [STEP_IDX_W-1:0] st_wr_idx;
  logic [STEP_IDX_W-1:0] st_rd_idx;
  step_t                 st_rd;
  step_t                 st_first;

  logic                  acc;
  logic                  wins;
  logic [15:0]           el_inc;
  logic [STEP_CNT_W-1:0] pos_inc;
  cmd_t                  cmd;

  // Frequency 0 and the rest code both mean silence
  function automatic logic [15:0] sound_of(input logic [15:0] f, input logic [15:0] rc);
    return ((f == 16'd0) || (f == rc)) ? 16'd0 : f;
  endfunction

  assign cmd       = cmd_t'(in_data.command);
  assign wins      = (mode_r == MODE_IDLE) || (in_data.priority_req >= prio_r);
  assign el_inc    = (elapsed_r == 16'hFFFF) ? elapsed_r : elapsed_r + 16'd1;
  assign pos_inc   = pos_r + STEP_CNT_W'(1);
  // pos_inc is below total_r whenever it is used, so it fits the index
  assign st_rd_idx = pos_inc[STEP_IDX_W-1:0];
  assign st_rd     = store_r[st_rd_idx];

  always_comb begin
    mode_nxt      = mode_r;
    prio_nxt      = prio_r;
    len_nxt       = len_r;
    elapsed_nxt   = elapsed_r;
    total_nxt     = total_r;
    pos_nxt       = pos_r;
    load_acc_nxt  = load_acc_r;
    load_open_nxt = load_open_r;
    freq_nxt      = freq_r;
    st_wr_en      = 1'b0;
    st_wr_idx     = total_r[STEP_IDX_W-1:0];
    st_first      = store_r[0];
    acc           = 1'b0;

    case (cmd)
      CMD_TICK: begin
        if (mode_r == MODE_TONE) begin
          elapsed_nxt = el_inc;
          if (el_inc >= len_r) begin
            freq_nxt = 16'd0;
            mode_nxt = MODE_IDLE;
          end
        end else if (mode_r == MODE_MELODY) begin
          elapsed_nxt = el_inc;
          if (el_inc >= len_r) begin
            pos_nxt = pos_inc;
            if (pos_inc >= total_r) begin
              freq_nxt = 16'd0;
              mode_nxt = MODE_IDLE;
            end else begin
              // advance to the next stored step
              elapsed_nxt = 16'd0;
              freq_nxt    = sound_of(st_rd.frequency, rest_code_r);
              len_nxt     = st_rd.duration;
            end
          end
        end
      end

      CMD_TONE, CMD_NOTE: begin
        if (wins && ((cmd == CMD_TONE) || (in_data.note_index < 4'(NOTE_COUNT)))) begin
          acc           = 1'b1;
          freq_nxt      = (cmd == CMD_TONE) ? sound_of(in_data.frequency, rest_code_r)
                                            : sound_of(pitch_of(in_data.note_index),
                                                       rest_code_r);
          len_nxt       = (cmd == CMD_TONE) ? in_data.duration : note_len_r;
          elapsed_nxt   = 16'd0;
          mode_nxt      = MODE_TONE;
          prio_nxt      = in_data.priority_req;
          load_open_nxt = 1'b0;
          load_acc_nxt  = 1'b0;
        end
      end

      CMD_MELODY: begin
        // first step of a load runs the priority check
        if (!load_open_r) begin
          load_open_nxt = 1'b1;
          load_acc_nxt  = wins;
          if (wins) begin
            freq_nxt  = 16'd0;
            mode_nxt  = MODE_LOADING;
            prio_nxt  = in_data.priority_req;
            total_nxt = '0;
          end
        end
        // drop steps beyond the store depth
        if (load_acc_nxt && (total_nxt < STEP_CNT_W'(MELODY_DEPTH))) begin
          st_wr_en  = 1'b1;
          st_wr_idx = total_nxt[STEP_IDX_W-1:0];
          if (total_nxt == '0) begin
            st_first = '{duration: in_data.duration, frequency: in_data.frequency};
          end
          total_nxt = total_nxt + STEP_CNT_W'(1);
        end
        if (in_data.last_step) begin
          load_open_nxt = 1'b0;
          if (load_acc_nxt && (total_nxt != '0)) begin
            pos_nxt     = '0;
            elapsed_nxt = 16'd0;
            freq_nxt    = sound_of(st_first.frequency, rest_code_r);
            len_nxt     = st_first.duration;
            mode_nxt    = MODE_MELODY;
          end
        end
        acc = load_acc_nxt;
      end

      CMD_STOP: begin
        freq_nxt      = 16'd0;
        mode_nxt      = MODE_IDLE;
        prio_nxt      = 2'd0;
        load_open_nxt = 1'b0;
        load_acc_nxt  = 1'b0;
        acc           = 1'b1;
      end

      default: begin
        // unknown command: no change, not accepted
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_IDLE;
      prio_r      <= 2'd0;
      len_r       <= 16'd0;
      elapsed_r   <= 16'd0;
      total_r     <= '0;
      pos_r       <= '0;
      load_acc_r  <= 1'b0;
      load_open_r <= 1'b0;
      freq_r      <= 16'd0;
    end else if (in_fire) begin
      mode_r      <= mode_nxt;
      prio_r      <= prio_nxt;
      len_r       <= len_nxt;
      elapsed_r   <= elapsed_nxt;
      total_r     <= total_nxt;
      pos_r       <= pos_nxt;
      load_acc_r  <= load_acc_nxt;
      load_open_r <= load_open_nxt;
      freq_r      <= freq_nxt;
    end
  end

  // Step store: payload only, written in load order
  always_ff @(posedge clk) begin
    if (in_fire && st_wr_en) begin
      store_r[st_wr_idx] <= '{duration: in_data.duration, frequency: in_data.frequency};
    end
  end

  // Result register: load on a transfer in, hold while stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= in_fire || (out_valid_r && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data_r <= '{tone_freq: freq_nxt,
                      playing:   (mode_nxt != MODE_IDLE),
                      accepted:  acc};
    end
  end

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_stop_silences: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (in_data.command == CMD_STOP)) |=>
      (out_data.tone_freq == 16'd0) && !out_data.playing && out_data.accepted)
    else $error("stop did not silence the sequencer");

  a_tick_not_accepted: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (in_data.command == CMD_TICK)) |=> !out_data.accepted)
    else $error("tick reported as accepted");

  a_melody_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == MODE_MELODY) |-> (pos_r < total_r))
    else $error("melody position beyond stored steps");

  a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
    total_r <= STEP_CNT_W'(MELODY_DEPTH))
    else $error("step count beyond store depth");

  a_idle_silent: assert property (@(posedge clk) disable iff (!rst_n)
    ((mode_r == MODE_IDLE) || (mode_r == MODE_LOADING)) |-> (freq_r == 16'd0))
    else $error("sound driven while idle or loading");

endmodule

// File: bench/tb_priority_tone_melody_sequencer.sv
// Self-checking bench for priority_tone_melody_sequencer: directed command table,
// then random tone, note, melody and stop traffic under several idling profiles.
// Depends on ptms_pkg and the sequencer RTL only.
module tb_priority_tone_melody_sequencer;
  import ptms_pkg::*;

  // Command codes outside the defined set are ignored by the block
  localparam logic [2:0] CMD_UNDEFINED = 3'd7;
  localparam int PHASE_COUNT = 6;
  localparam int PHASE_ITEMS = 275;
  localparam int DIRECTED_ROWS = 25;

  localparam logic [15:0] NOTE_PITCH [NOTE_COUNT] = '{
    16'd523, 16'd587, 16'd659, 16'd698, 16'd784, 16'd880, 16'd988,
    16'd1047, 16'd1175, 16'd1319, 16'd1397, 16'd1568, 16'd1760
  };

  // Register values per random phase: the extremes, zero, and a rest code that
  // collides with a pitch table entry so that table note falls silent
  localparam logic [15:0] PHASE_REST [PHASE_COUNT] = '{
    16'd440, 16'hFFFF, 16'd0, 16'd1, 16'd523, 16'd7
  };
  localparam logic [15:0] PHASE_NOTE_LEN [PHASE_COUNT] = '{
    16'd3, 16'd0, 16'hFFFF, 16'd1, 16'd5, 16'd2
  };
  // Idling profiles: none, sender only, receiver only, both
  localparam int SEND_IDLE [4] = '{0, 62, 0, 38};
  localparam int RECV_STALL [4] = '{0, 0, 62, 38};

  typedef struct packed {
    in_t  item;
    logic typed;
    out_t want;
  } directed_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_t         in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_t        out_data;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  // Predicted sequencer state
  mode_t       snd_mode;
  logic [1:0]  snd_prio;
  logic [15:0] snd_len;
  logic [15:0] snd_elapsed;
  logic [15:0] snd_freq;
  step_t       steps [MELODY_DEPTH];
  int          step_count;
  int          step_at;
  logic        load_open;
  logic        load_won;
  logic [15:0] rest_reg;
  logic [15:0] note_len_reg;

  out_t pending_sounds [$];
  directed_row_t dtab [DIRECTED_ROWS];

  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_left = 0;
  int sent_count = 0;
  int results_seen = 0;
  int mismatches = 0;

  priority_tone_melody_sequencer uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #10 clk = ~clk;

  // Hard stop in case the block hangs; far above the slowest legal run
  initial begin
    #8_000_000;
    $display("priority_tone_melody_sequencer: mismatch");
    $finish;
  end

  task automatic note_mismatch(input string what, input logic [31:0] want,
                               input logic [31:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("%t %s: expected %0h, got %0h", $realtime, what, want, got);
  endtask

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Zero and the rest code both mean silence
  function automatic logic [15:0] audible(input logic [15:0] f);
    return (f == 16'd0 || f == rest_reg) ? 16'd0 : f;
  endfunction

  function automatic logic outranks(input logic [1:0] prio);
    return snd_mode == MODE_IDLE || prio >= snd_prio;
  endfunction

  // Silence and go idle; the priority is kept unless the caller clears it
  function automatic void fall_silent();
    snd_freq = '0;
    snd_mode = MODE_IDLE;
  endfunction

  function automatic logic take_tone(input logic [15:0] f, input logic [15:0] d,
                                     input logic [1:0] prio);
    if (!outranks(prio))
      return 1'b0;
    snd_freq    = audible(f);
    snd_len     = d;
    snd_elapsed = '0;
    snd_mode    = MODE_TONE;
    snd_prio    = prio;
    load_open   = 1'b0;
    load_won    = 1'b0;
    return 1'b1;
  endfunction

  // Apply one command to the predicted state and return the result it drives
  function automatic out_t next_sound(input in_t c);
    out_t r;
    logic won;
    won = 1'b0;
    case (c.command)
      CMD_TICK: begin
        if (snd_mode == MODE_TONE || snd_mode == MODE_MELODY) begin
          if (snd_elapsed != 16'hFFFF)
            snd_elapsed++;
          if (snd_mode == MODE_TONE) begin
            if (snd_elapsed >= snd_len)
              fall_silent();
          end else if (snd_elapsed >= steps[step_at].duration) begin
            // Advance at most one melody step per tick
            step_at++;
            if (step_at >= step_count) begin
              fall_silent();
            end else begin
              snd_elapsed = '0;
              snd_freq    = audible(steps[step_at].frequency);
            end
          end
        end
      end
      CMD_TONE: won = take_tone(c.frequency, c.duration, c.priority_req);
      CMD_MELODY: begin
        // Only the first step of a load runs the priority check
        if (!load_open) begin
          load_open = 1'b1;
          load_won  = outranks(c.priority_req);
          if (load_won) begin
            snd_freq   = '0;
            snd_mode   = MODE_LOADING;
            snd_prio   = c.priority_req;
            step_count = 0;
          end
        end
        // Drop steps beyond the store depth
        if (load_won && step_count < MELODY_DEPTH) begin
          steps[step_count] = {c.duration, c.frequency};
          step_count++;
        end
        if (c.last_step) begin
          load_open = 1'b0;
          if (load_won && step_count > 0) begin
            step_at     = 0;
            snd_elapsed = '0;
            snd_freq    = audible(steps[0].frequency);
            snd_mode    = MODE_MELODY;
          end
        end
        won = load_won;
      end
      CMD_NOTE: begin
        if (c.note_index < NOTE_COUNT)
          won = take_tone(NOTE_PITCH[c.note_index], note_len_reg, c.priority_req);
      end
      CMD_STOP: begin
        fall_silent();
        snd_prio  = '0;
        load_open = 1'b0;
        load_won  = 1'b0;
        won       = 1'b1;
      end
      default: ;
    endcase
    r.tone_freq = snd_freq;
    r.playing   = snd_mode != MODE_IDLE;
    r.accepted  = won;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic directed_row_t drow(input logic [2:0] cmd, input int f, input int d,
                                         input int p, input int idx, input bit last,
                                         input bit typed, input int wf, input bit wp,
                                         input bit wa);
    directed_row_t r;
    r.item.command      = cmd;
    r.item.frequency    = f[15:0];
    r.item.duration     = d[15:0];
    r.item.priority_req = p[1:0];
    r.item.note_index   = idx[3:0];
    r.item.last_step    = last;
    r.typed             = typed;
    r.want.tone_freq    = wf[15:0];
    r.want.playing      = wp;
    r.want.accepted     = wa;
    return r;
  endfunction

  function automatic in_t noise_item();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    return raw[$bits(in_t)-1:0];
  endfunction

  // Random item of a given command, with pitches and lengths biased toward the
  // interesting values and short durations so ticks actually end things
  function automatic in_t shaped(input logic [2:0] cmd);
    in_t c;
    c = noise_item();
    c.command = cmd;
    case ($urandom_range(0, 9))
      0:       c.frequency = '0;
      1:       c.frequency = rest_reg;
      2:       c.frequency = 16'hFFFF;
      default: ;
    endcase
    case ($urandom_range(0, 15))
      0:       c.duration = 16'hFFFF;
      1:       ;
      2, 3:    c.duration = 16'($urandom_range(5, 40));
      default: c.duration = 16'($urandom_range(0, 4));
    endcase
    return c;
  endfunction

  // Offer one command, idling first at the phase's rate, and hold it until the
  // transfer; the expected result is queued at the transfer edge
  task automatic send_cmd(input in_t c, input logic typed = 1'b0, input out_t want = '0);
    logic took;
    out_t predicted;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= c;
    // Decide at the falling edge, where valid and stall are settled
    do begin
      @(negedge clk);
      took = !in_stall;
      @(posedge clk);
    end while (!took);
    predicted = next_sound(c);
    pending_sounds.push_back(typed ? want : predicted);
    if (c.command <= CMD_STOP)
      sent_count++;
  endtask

  // Drop valid and wait until every queued result has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_sounds.size() != 0);
  endtask

  // APB write, then a read back of the same register
  task automatic write_reg(input logic idx, input logic [15:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= {16'h0000, value};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(negedge clk);
    if (cfg_prdata[15:0] !== value)
      note_mismatch("register read back", 32'(value), cfg_prdata);
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    if (idx == REG_REST_CODE)
      rest_reg = value;
    else
      note_len_reg = value;
  endtask

  // One burst of traffic: mostly complete melodies, tones and notes followed by
  // ticks, with broken loads, stops and raw noise mixed in
  task automatic play_scenario();
    in_t c;
    int n;
    int kind;
    kind = $urandom_range(0, 9);
    if (kind <= 4) begin
      // Occasionally load more steps than the store holds
      n = ($urandom_range(0, 4) == 0) ? $urandom_range(14, 20) : $urandom_range(1, 6);
      for (int s = 0; s < n; s++) begin
        c = shaped(CMD_MELODY);
        c.last_step = (s == n - 1) && (kind != 4);
        send_cmd(c);
      end
      // Break an open load with something else
      if (kind == 4) begin
        case ($urandom_range(0, 3))
          0:       send_cmd(shaped(CMD_TONE));
          1:       send_cmd(shaped(CMD_NOTE));
          2:       send_cmd(shaped(CMD_STOP));
          default: send_cmd(shaped(CMD_TICK));
        endcase
      end
    end else if (kind <= 6) begin
      send_cmd(shaped(CMD_TONE));
    end else if (kind == 7) begin
      send_cmd(shaped(CMD_NOTE));
    end else if (kind == 8) begin
      send_cmd(shaped(CMD_STOP));
    end else begin
      send_cmd(noise_item());
    end
    repeat ($urandom_range(0, 10)) send_cmd(shaped(CMD_TICK));
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: stall at the phase's rate, or hold off for a requested stretch
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // Compare each result transfer with the oldest expectation; sample at the
  // falling edge so the transfer at the next rising edge is what gets checked
  always @(negedge clk) begin : check_results
    out_t want;
    if (rst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
      results_seen++;
      if (pending_sounds.size() == 0) begin
        note_mismatch("result with nothing expected", '0, 32'(out_data));
      end else begin
        want = pending_sounds.pop_front();
        if (out_data.tone_freq !== want.tone_freq)
          note_mismatch("tone_freq", 32'(want.tone_freq), 32'(out_data.tone_freq));
        if (out_data.playing !== want.playing)
          note_mismatch("playing", 32'(want.playing), 32'(out_data.playing));
        if (out_data.accepted !== want.accepted)
          note_mismatch("accepted", 32'(want.accepted), 32'(out_data.accepted));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int goal;
    int prof;

    snd_mode     = MODE_IDLE;
    snd_prio     = '0;
    snd_len      = '0;
    snd_elapsed  = '0;
    snd_freq     = '0;
    step_count   = 0;
    step_at      = 0;
    load_open    = 1'b0;
    load_won     = 1'b0;
    rest_reg     = REST_CODE_INIT;
    note_len_reg = NOTE_LENGTH_INIT;

    // cmd, freq, dur, prio, index, last | typed, freq, playing, accepted
    dtab[0]  = drow(CMD_TICK,      0,     0,     0, 0,  0, 1, 0,     0, 0);
    dtab[1]  = drow(CMD_TONE,      65535, 1,     1, 0,  0, 1, 65535, 1, 1);
    dtab[2]  = drow(CMD_TONE,      500,   1,     0, 0,  0, 1, 65535, 1, 0);
    dtab[3]  = drow(CMD_TICK,      0,     0,     0, 0,  0, 1, 0,     0, 0);
    dtab[4]  = drow(CMD_TONE,      500,   0,     0, 0,  0, 1, 500,   1, 1);
    dtab[5]  = drow(CMD_TICK,      0,     0,     0, 0,  0, 1, 0,     0, 0);
    dtab[6]  = drow(CMD_NOTE,      0,     0,     3, 0,  0, 1, 523,   1, 1);
    dtab[7]  = drow(CMD_NOTE,      0,     0,     2, 12, 0, 1, 523,   1, 0);
    dtab[8]  = drow(CMD_NOTE,      0,     0,     3, 13, 0, 1, 523,   1, 0);
    dtab[9]  = drow(CMD_STOP,      0,     0,     0, 0,  0, 1, 0,     0, 1);
    dtab[10] = drow(CMD_TONE,      0,     65535, 0, 0,  0, 1, 0,     1, 1);
    dtab[11] = drow(CMD_UNDEFINED, 0,     0,     0, 0,  0, 1, 0,     1, 0);
    dtab[12] = drow(CMD_STOP,      0,     0,     0, 0,  0, 1, 0,     0, 1);
    dtab[13] = drow(CMD_MELODY,    440,   1,     2, 0,  0, 1, 0,     1, 1);
    dtab[14] = drow(CMD_TICK,      0,     0,     0, 0,  0, 1, 0,     1, 0);
    dtab[15] = drow(CMD_MELODY,    0,     0,     0, 0,  0, 1, 0,     1, 1);
    dtab[16] = drow(CMD_MELODY,    880,   0,     0, 0,  1, 1, 440,   1, 1);
    dtab[17] = drow(CMD_MELODY,    1,     1,     0, 0,  0, 1, 440,   1, 0);
    dtab[18] = drow(CMD_MELODY,    2,     2,     3, 0,  1, 1, 440,   1, 0);
    dtab[19] = drow(CMD_TICK,      0,     0,     0, 0,  0, 0, 0,     0, 0);
    dtab[20] = drow(CMD_TICK,      0,     0,     0, 0,  0, 0, 0,     0, 0);
    dtab[21] = drow(CMD_TICK,      0,     0,     0, 0,  0, 0, 0,     0, 0);
    dtab[22] = drow(CMD_MELODY,    300,   5,     0, 0,  0, 1, 0,     1, 1);
    dtab[23] = drow(CMD_TONE,      700,   3,     3, 0,  0, 1, 700,   1, 1);
    dtab[24] = drow(CMD_STOP,      0,     0,     0, 0,  0, 1, 0,     0, 1);

    // Reset once
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Start from the reset values so the typed rows hold
    write_reg(REG_REST_CODE, REST_CODE_INIT);
    write_reg(REG_NOTE_LENGTH, NOTE_LENGTH_INIT);

    // Directed rows at full rate
    for (int i = 0; i < DIRECTED_ROWS; i++)
      send_cmd(dtab[i].item, dtab[i].typed, dtab[i].want);
    drain_results();

    for (int p = 0; p < PHASE_COUNT; p++) begin
      // Registers change only with nothing in flight
      write_reg(REG_REST_CODE, (p == 3) ? 16'($urandom) : PHASE_REST[p]);
      write_reg(REG_NOTE_LENGTH, PHASE_NOTE_LEN[p]);
      prof          = p % 4;
      send_idle_pct = SEND_IDLE[prof];
      stall_pct     = RECV_STALL[prof];
      // Hold the receiver off while the sender keeps offering, to back up the
      // output register and force input stall
      hold_left <= 80;
      goal = sent_count + PHASE_ITEMS;
      while (sent_count < goal) begin
        play_scenario();
        // Pause the sender midway until the block has caught up
        if (p == 2 && sent_count >= goal - PHASE_ITEMS / 2 && sent_count < goal - 100)
          drain_results();
      end
      drain_results();
    end

    send_idle_pct = 0;
    stall_pct     = 0;
    repeat (5) @(posedge clk);

    $display("Ran %0d commands through directed rows and %0d register settings,",
             sent_count, PHASE_COUNT + 1);
    $display("checked %0d results across idle and stall profiles", results_seen);
    if (mismatches == 0 && pending_sounds.size() == 0) begin
      $display("priority_tone_melody_sequencer: match");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("priority_tone_melody_sequencer: mismatch");
    end
    $finish;
  end

endmodule
